// ----- sv/ncst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ncst_pkg;
	typedef enum logic [1:0] {
		OP_OPEN   = 2'd0,
		OP_WAIT   = 2'd1,
		OP_POST   = 2'd2,
		OP_UNLINK = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	localparam int NAME_W = 160;
	localparam int INIT_W = 15;
	localparam int COUNT_W = 16;
	localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7fff;
	localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;
endpackage
`default_nettype wire

// ----- sv/ncst_name_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ncst_name_scan #(
	parameter int ENTRIES = 32,
	parameter int IDX_W = 5
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [ncst_pkg::NAME_W-1:0] key,
	input  wire logic [ENTRIES-1:0]         open_mask,
	input  wire logic [ncst_pkg::NAME_W-1:0] rd_name,
	output logic      [IDX_W-1:0]           rd_idx,
	output logic                            done,
	output logic                            match_found,
	output logic      [IDX_W-1:0]           match_idx,
	output logic                            free_found,
	output logic      [IDX_W-1:0]           free_idx
);
	import ncst_pkg::*;

	localparam int CNT_W = IDX_W + 1;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(ENTRIES - 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic             chk_q;
	logic [IDX_W-1:0] chk_idx_q;
	logic             mf_q, ff_q;
	logic [IDX_W-1:0] mi_q, fi_q;
	logic             hit;

	assign rd_idx = cnt_q[IDX_W-1:0];
	assign hit = open_mask[chk_idx_q] && (rd_name == key);
	assign match_found = mf_q;
	assign match_idx = mi_q;
	assign free_found = ff_q;
	assign free_idx = fi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			chk_q <= 1'b0;
			chk_idx_q <= '0;
			mf_q <= 1'b0;
			ff_q <= 1'b0;
			mi_q <= '0;
			fi_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				chk_q <= 1'b0;
				mf_q <= 1'b0;
				ff_q <= 1'b0;
			end else begin
				chk_q <= busy_q;
				chk_idx_q <= rd_idx;
				if (busy_q) begin
					if (cnt_q == LAST)
						busy_q <= 1'b0;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				if (chk_q) begin
					if (hit && !mf_q) begin
						mf_q <= 1'b1;
						mi_q <= chk_idx_q;
					end
					if (!open_mask[chk_idx_q] && !ff_q) begin
						ff_q <= 1'b1;
						fi_q <= chk_idx_q;
					end
					if (chk_idx_q == LAST_IDX)
						done <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- sv/named_counting_semaphore_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Named counting semaphore table. One item is taken at a time; stall stays high
// until its result is taken. Open and unlink sweep the name store one entry per
// cycle through a single comparator, then give their result. Wait and post
// give theirs after the count and head read, the link read and the update; an
// out-of-range handle, or an out-of-range task on a wait, answers not found
// from the read step. Post wakes the oldest waiter of the entry in FIFO order,
// and counts saturate at the signed 16-bit limits.
module named_counting_semaphore_table #(
	parameter int SEM_ENTRIES = 32,
	parameter int MAX_TASKS = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     op,
	input  wire logic [63:0]                    name_bytes_low,
	input  wire logic [63:0]                    name_bytes_mid,
	input  wire logic [31:0]                    name_bytes_high,
	input  wire logic [14:0]                    initial_count,
	input  wire logic [$clog2(SEM_ENTRIES)-1:0] sem_handle,
	input  wire logic [$clog2(MAX_TASKS)-1:0]   caller_task,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [1:0]                          status,
	output logic [$clog2(SEM_ENTRIES)-1:0]      handle_out,
	output logic                                must_block,
	output logic                                wake_valid,
	output logic [$clog2(MAX_TASKS)-1:0]        wake_task
);
	import ncst_pkg::*;

	localparam int IDX_W = $clog2(SEM_ENTRIES);
	localparam int TASK_W = $clog2(MAX_TASKS);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_READ = 6'b000100,
		S_UPD  = 6'b001000,
		S_LINK = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;

	logic [NAME_W-1:0]  name_mem [SEM_ENTRIES];
	logic [COUNT_W-1:0] count_mem [SEM_ENTRIES];
	logic [TASK_W-1:0]  tail_mem [SEM_ENTRIES];
	logic [TASK_W-1:0]  link_mem [MAX_TASKS];
	logic [TASK_W-1:0]  head_mem [SEM_ENTRIES];
	logic [SEM_ENTRIES-1:0] open_q;
	logic [SEM_ENTRIES-1:0] qne_q;
	logic [SEM_ENTRIES-1:0] cnt_ok_q;

	logic [1:0]         op_q;
	logic [NAME_W-1:0]  key_q;
	logic [INIT_W-1:0]  init_q;
	logic [IDX_W-1:0]   h_q;
	logic [TASK_W-1:0]  task_q;
	logic               bad_q;

	logic [NAME_W-1:0]  rd_name_q;
	logic [COUNT_W-1:0] cnt_rd_q;
	logic               cnt_ok_rd_q;
	logic [TASK_W-1:0]  tail_rd_q, head_rd_q, link_rd_q;
	logic               scan_start;
	logic [IDX_W-1:0]   scan_idx;
	logic               scan_done, mf, ff;
	logic [IDX_W-1:0]   mi, fi;
	logic signed [COUNT_W-1:0] cnt_new;

	logic [1:0]        st_q;
	logic [IDX_W-1:0]  ho_q;
	logic              blk_q, wv_q;
	logic [TASK_W-1:0] wt_q;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status = st_q;
	assign handle_out = ho_q;
	assign must_block = blk_q;
	assign wake_valid = wv_q;
	assign wake_task = wt_q;
	assign scan_start = (state_q == S_IDLE) && in_valid &&
		((op == OP_OPEN) || (op == OP_UNLINK));

	ncst_name_scan #(.ENTRIES(SEM_ENTRIES), .IDX_W(IDX_W)) u_scan (
		.clk(clk), .arst_n(arst_n), .start(scan_start), .key(key_q),
		.open_mask(open_q), .rd_name(rd_name_q), .rd_idx(scan_idx),
		.done(scan_done), .match_found(mf), .match_idx(mi),
		.free_found(ff), .free_idx(fi)
	);

	always_ff @(posedge clk) begin
		rd_name_q <= name_mem[scan_idx];
		cnt_rd_q <= count_mem[h_q];
		cnt_ok_rd_q <= cnt_ok_q[h_q];
		tail_rd_q <= tail_mem[h_q];
		head_rd_q <= head_mem[h_q];
		link_rd_q <= link_mem[head_rd_q];
	end

	logic signed [COUNT_W-1:0] cs;
	always_comb begin
		cs = cnt_ok_rd_q ? cnt_rd_q : '0;
		if (op_q == OP_WAIT)
			cnt_new = (cs == COUNT_MIN) ? cs : cs - 16'sd1;
		else
			cnt_new = (cs == COUNT_MAX) ? cs : cs + 16'sd1;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q <= op;
			key_q <= {name_bytes_high, name_bytes_mid, name_bytes_low};
			init_q <= initial_count;
			h_q <= sem_handle;
			task_q <= caller_task;
			bad_q <= (32'(sem_handle) >= SEM_ENTRIES) ||
				((op == OP_WAIT) && (32'(caller_task) >= MAX_TASKS));
		end
		if (state_q == S_SCAN && scan_done) begin
			if (op_q == OP_OPEN && !mf && ff) begin
				name_mem[fi] <= key_q;
				count_mem[fi] <= COUNT_W'(init_q);
			end
			if (op_q == OP_UNLINK && mf)
				count_mem[mi] <= '0;
		end
		if (state_q == S_UPD) begin
			count_mem[h_q] <= cnt_new;
			if (op_q == OP_WAIT && cnt_new[COUNT_W-1]) begin
				tail_mem[h_q] <= task_q;
				if (!qne_q[h_q])
					head_mem[h_q] <= task_q;
				else
					link_mem[tail_rd_q] <= task_q;
			end
			if (op_q == OP_POST && !(cnt_new > 16'sd0) && qne_q[h_q] &&
				head_rd_q != tail_rd_q)
				head_mem[h_q] <= link_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			open_q <= '0;
			qne_q <= '0;
			cnt_ok_q <= '0;
			st_q <= '0;
			ho_q <= '0;
			blk_q <= 1'b0;
			wv_q <= 1'b0;
			wt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						st_q <= ST_OK;
						ho_q <= '0;
						blk_q <= 1'b0;
						wv_q <= 1'b0;
						wt_q <= '0;
						if (op == OP_OPEN || op == OP_UNLINK)
							state_q <= S_SCAN;
						else
							state_q <= S_READ;
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						state_q <= S_OUT;
						if (op_q == OP_OPEN) begin
							if (mf)
								ho_q <= mi;
							else if (ff) begin
								ho_q <= fi;
								open_q[fi] <= 1'b1;
								qne_q[fi] <= 1'b0;
								cnt_ok_q[fi] <= 1'b1;
							end else
								st_q <= ST_FULL;
						end else begin
							if (mf) begin
								open_q[mi] <= 1'b0;
								qne_q[mi] <= 1'b0;
								cnt_ok_q[mi] <= 1'b1;
							end else
								st_q <= ST_NOT_FOUND;
						end
					end
				end
				S_READ: begin
					if (bad_q) begin
						st_q <= ST_NOT_FOUND;
						state_q <= S_OUT;
					end else
						state_q <= S_LINK;
				end
				S_LINK: state_q <= S_UPD;
				S_UPD: begin
					state_q <= S_OUT;
					cnt_ok_q[h_q] <= 1'b1;
					if (op_q == OP_WAIT) begin
						if (cnt_new[COUNT_W-1]) begin
							blk_q <= 1'b1;
							qne_q[h_q] <= 1'b1;
						end
					end else if (!(cnt_new > 16'sd0) && qne_q[h_q]) begin
						wv_q <= 1'b1;
						wt_q <= head_rd_q;
						if (head_rd_q == tail_rd_q)
							qne_q[h_q] <= 1'b0;
					end
				end
				S_OUT: begin
					if (!out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import ncst_pkg::*;

	typedef struct {
		op_t         op;
		logic [63:0] lo;
		logic [63:0] mid;
		logic [31:0] hi;
		logic [14:0] init;
		logic [4:0]  hdl;
		logic [5:0]  task_id;
	} sem_req_t;

	typedef struct {
		status_t    st;
		logic [4:0] hdl;
		logic       blk;
		logic       wv;
		logic [5:0] wt;
	} sem_rsp_t;

	typedef struct {
		sem_req_t req;
		bit       typed;
		sem_rsp_t rsp;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [63:0] name_bytes_low;
	logic [63:0] name_bytes_mid;
	logic [31:0] name_bytes_high;
	logic [14:0] initial_count;
	logic [4:0]  sem_handle;
	logic [5:0]  caller_task;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [4:0]  handle_out;
	logic        must_block;
	logic        wake_valid;
	logic [5:0]  wake_task;

	named_counting_semaphore_table u_dut (.*);

	bit                 slot_open [32];
	logic [63:0]        slot_lo [32];
	logic [63:0]        slot_mid [32];
	logic [31:0]        slot_hi [32];
	logic signed [16:0] slot_count [32];
	int                 q_head [32];
	int                 q_tail [32];
	int                 task_next [64];

	sem_rsp_t   pending_rsp[$];
	int         errors;
	int         stall_left;
	int         idle_cycles;
	bit         quiet;
	logic [63:0] pool_lo [40];
	logic [63:0] pool_mid [40];
	logic [31:0] pool_hi [40];

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic int find_slot(logic [63:0] lo, logic [63:0] mid, logic [31:0] hi);
		for (int i = 0; i < 32; i++)
			if (slot_open[i] && slot_lo[i] == lo && slot_mid[i] == mid && slot_hi[i] == hi)
				return i;
		return -1;
	endfunction

	function automatic sem_rsp_t semaphore_step(sem_req_t r);
		sem_rsp_t s;
		int i;
		int t;
		s = '{ST_OK, 5'd0, 1'b0, 1'b0, 6'd0};
		case (r.op)
			OP_OPEN: begin
				i = find_slot(r.lo, r.mid, r.hi);
				if (i < 0) begin
					for (i = 0; i < 32; i++)
						if (!slot_open[i])
							break;
					if (i < 32) begin
						slot_open[i] = 1;
						slot_lo[i] = r.lo;
						slot_mid[i] = r.mid;
						slot_hi[i] = r.hi;
						slot_count[i] = {2'b00, r.init};
						q_head[i] = -1;
					end else
						i = -1;
				end
				if (i < 0)
					s.st = ST_FULL;
				else
					s.hdl = i[4:0];
			end
			OP_WAIT: begin
				i = r.hdl;
				if (slot_count[i] > -32768)
					slot_count[i]--;
				if (slot_count[i] < 0) begin
					if (q_head[i] < 0)
						q_head[i] = r.task_id;
					else
						task_next[q_tail[i]] = r.task_id;
					q_tail[i] = r.task_id;
					s.blk = 1;
				end
			end
			OP_POST: begin
				i = r.hdl;
				if (slot_count[i] < 32767)
					slot_count[i]++;
				if (slot_count[i] <= 0 && q_head[i] >= 0) begin
					t = q_head[i];
					s.wv = 1;
					s.wt = t[5:0];
					if (t == q_tail[i])
						q_head[i] = -1;
					else
						q_head[i] = task_next[t];
				end
			end
			default: begin
				i = find_slot(r.lo, r.mid, r.hi);
				if (i < 0)
					s.st = ST_NOT_FOUND;
				else begin
					slot_open[i] = 0;
					slot_count[i] = 0;
					q_head[i] = -1;
				end
			end
		endcase
		return s;
	endfunction

	task automatic issue(sem_req_t r, bit typed, sem_rsp_t typed_rsp);
		int gap;
		sem_rsp_t p;
		gap = quiet ? 0 : $urandom_range(0, 17);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		op <= r.op;
		name_bytes_low <= r.lo;
		name_bytes_mid <= r.mid;
		name_bytes_high <= r.hi;
		initial_count <= r.init;
		sem_handle <= r.hdl;
		caller_task <= r.task_id;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		p = semaphore_step(r);
		pending_rsp.push_back(typed ? typed_rsp : p);
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1;
			stall_left--;
		end else
			out_stall <= 0;
	end

	always @(posedge clk) begin
		sem_rsp_t e;
		if (out_valid && !out_stall) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: result with none expected: status %0d handle %0d", $time,
					status, handle_out);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				if (status !== e.st || handle_out !== e.hdl || must_block !== e.blk ||
					wake_valid !== e.wv || wake_task !== e.wt) begin
					$display("%0t: expected st %0d h %0d blk %0b wv %0b wt %0d, got %0d %0d %0b %0b %0d",
						$time, e.st, e.hdl, e.blk, e.wv, e.wt,
						status, handle_out, must_block, wake_valid, wake_task);
					errors++;
				end
			end
			stall_left = quiet ? 0 : $urandom_range(0, 17);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 3000) begin
			$display("tb failed");
			$finish;
		end
	end

	function automatic sem_req_t mk(op_t o, logic [63:0] lo, logic [63:0] mid, logic [31:0] hi,
		logic [14:0] init, logic [4:0] hdl, logic [5:0] tk);
		sem_req_t r;
		r = '{o, lo, mid, hi, init, hdl, tk};
		return r;
	endfunction

	function automatic sem_rsp_t rsp(status_t st, logic [4:0] h, logic b, logic wv,
		logic [5:0] wt);
		sem_rsp_t s;
		s = '{st, h, b, wv, wt};
		return s;
	endfunction

	initial begin
		dir_row_t dir [$];
		sem_req_t r;
		sem_rsp_t none;
		int k;
		int pick;
		logic [63:0] ones;
		errors = 0;
		stall_left = 0;
		idle_cycles = 0;
		quiet = 0;
		arst_n = 0;
		in_valid = 0;
		out_stall = 0;
		op = OP_OPEN;
		name_bytes_low = 0;
		name_bytes_mid = 0;
		name_bytes_high = 0;
		initial_count = 0;
		sem_handle = 0;
		caller_task = 0;
		for (int i = 0; i < 32; i++) begin
			slot_open[i] = 0;
			slot_lo[i] = 0;
			slot_mid[i] = 0;
			slot_hi[i] = 0;
			slot_count[i] = 0;
			q_head[i] = -1;
			q_tail[i] = 0;
		end
		for (int i = 0; i < 64; i++)
			task_next[i] = 0;
		none = rsp(ST_OK, 0, 0, 0, 0);
		ones = '1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		dir.push_back('{mk(OP_OPEN, 64'h41, 0, 0, 15'd5, 0, 0), 1, rsp(ST_OK, 0, 0, 0, 0)});
		dir.push_back('{mk(OP_OPEN, 64'h41, 0, 0, 15'd9, 0, 0), 1, rsp(ST_OK, 0, 0, 0, 0)});
		dir.push_back('{mk(OP_OPEN, ones, ones, '1, 15'h7fff, 0, 0), 1,
			rsp(ST_OK, 1, 0, 0, 0)});
		dir.push_back('{mk(OP_POST, 0, 0, 0, 0, 1, 0), 1, rsp(ST_OK, 0, 0, 0, 0)});
		dir.push_back('{mk(OP_WAIT, 0, 0, 0, 0, 0, 63), 1, rsp(ST_OK, 0, 0, 0, 0)});
		dir.push_back('{mk(OP_UNLINK, 64'h42, 0, 0, 0, 0, 0), 1,
			rsp(ST_NOT_FOUND, 0, 0, 0, 0)});
		dir.push_back('{mk(OP_WAIT, 0, 0, 0, 0, 2, 0), 1, rsp(ST_OK, 0, 1, 0, 0)});
		dir.push_back('{mk(OP_POST, 0, 0, 0, 0, 2, 0), 1, rsp(ST_OK, 0, 0, 1, 0)});
		dir.push_back('{mk(OP_POST, 0, 0, 0, 0, 2, 0), 1, rsp(ST_OK, 0, 0, 0, 0)});
		dir.push_back('{mk(OP_UNLINK, ones, ones, '1, 0, 0, 0), 1, rsp(ST_OK, 0, 0, 0, 0)});
		dir.push_back('{mk(OP_OPEN, 0, 0, 0, 0, 0, 0), 1, rsp(ST_OK, 1, 0, 0, 0)});
		dir.push_back('{mk(OP_OPEN, 64'h41, 0, 32'h1, 0, 0, 0), 1, rsp(ST_OK, 2, 0, 0, 0)});
		dir.push_back('{mk(OP_WAIT, 0, 0, 0, 0, 3, 5), 0, none});
		dir.push_back('{mk(OP_WAIT, 0, 0, 0, 0, 3, 6), 0, none});
		dir.push_back('{mk(OP_WAIT, 0, 0, 0, 0, 3, 5), 0, none});
		dir.push_back('{mk(OP_POST, 0, 0, 0, 0, 3, 0), 0, none});
		dir.push_back('{mk(OP_POST, 0, 0, 0, 0, 3, 0), 0, none});
		dir.push_back('{mk(OP_POST, 0, 0, 0, 0, 3, 0), 0, none});
		dir.push_back('{mk(OP_POST, 0, 0, 0, 0, 3, 0), 0, none});
		dir.push_back('{mk(OP_WAIT, 0, 0, 0, 0, 31, 63), 0, none});
		dir.push_back('{mk(OP_UNLINK, 0, 0, 0, 0, 0, 0), 1, rsp(ST_OK, 0, 0, 0, 0)});
		dir.push_back('{mk(OP_POST, 0, 0, 0, 0, 31, 0), 0, none});
		foreach (dir[i])
			issue(dir[i].req, dir[i].typed, dir[i].rsp);

		for (int i = 0; i < 40; i++) begin
			pool_lo[i] = {$urandom, $urandom};
			pool_mid[i] = ($urandom_range(0, 1)) ? {$urandom, $urandom} : 64'd0;
			pool_hi[i] = ($urandom_range(0, 1)) ? $urandom : 32'd0;
		end

		for (int n = 0; n < 2000; n++) begin
			if (n % 250 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (n == 1000) begin
				@(negedge clk);
				in_valid <= 0;
				while (pending_rsp.size() != 0)
					@(posedge clk);
			end
			k = $urandom_range(0, 99);
			pick = $urandom_range(0, 39);
			r = mk(OP_OPEN, pool_lo[pick], pool_mid[pick], pool_hi[pick],
				($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 3)),
				($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 5)) : 5'($urandom),
				6'($urandom));
			if (k < 25)
				r.op = OP_OPEN;
			else if (k < 55)
				r.op = OP_WAIT;
			else if (k < 85)
				r.op = OP_POST;
			else
				r.op = OP_UNLINK;
			if ($urandom_range(0, 19) == 0) begin
				r.lo = {$urandom, $urandom};
				r.mid = {$urandom, $urandom};
				r.hi = $urandom;
			end
			issue(r, 0, none);
		end

		@(negedge clk);
		in_valid <= 0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule

// ----- filelist.f -----
sv/ncst_pkg.sv
sv/ncst_name_scan.sv
sv/named_counting_semaphore_table.sv
bench/tb.sv
